// ----- src/pmsd_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsd_pkg
// Shared widths for the per-pixel mean / standard deviation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pmsd_pkg;

    localparam int SUM_W  = 32;  // sum of samples
    localparam int SQS_W  = 48;  // sum of squared samples
    localparam int CNT_W  = 16;  // sample count
    localparam int OUT_W  = 24;  // result fields
    localparam int PROD_W = 64;  // square_sum * count and sample_sum^2

endpackage

`default_nettype wire

// ----- src/pmsd_divider.sv -----
// ----------------------------------------------------------------------------
// pmsd_divider
// Pipelined restoring divider: one quotient bit per stage, saturating
// 24-bit quotient by a 16-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pmsd_divider #(
    parameter int DIVIDEND_W = 40
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [DIVIDEND_W-1:0]        dividend,
    input  wire logic [pmsd_pkg::CNT_W-1:0]   divisor,
    output logic      [pmsd_pkg::OUT_W-1:0]   quotient
);

    localparam int OW    = pmsd_pkg::OUT_W;
    localparam int NW    = pmsd_pkg::CNT_W;
    localparam int HI_W  = DIVIDEND_W - OW;
    localparam int CW    = (HI_W > NW) ? HI_W : NW;
    localparam int STEPS = OW;

    logic [NW-1:0] rem_reg [STEPS];
    logic [OW-1:0] low_reg [STEPS];
    logic [NW-1:0] dvs_reg [STEPS];
    logic          ovf_reg [STEPS];

    logic [CW-1:0] hi_ext;
    logic          ovf_in;

    // The quotient fits in 24 bits only when the upper dividend bits are
    // below the divisor; those bits then seed the partial remainder.
    assign hi_ext = CW'(dividend[DIVIDEND_W-1:OW]);
    assign ovf_in = (hi_ext >= CW'(divisor));

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [NW-1:0] rem_in;
        logic [OW-1:0] low_in;
        logic [NW-1:0] dvs_in;
        logic          ovf_in_k;
        logic [NW:0]   trial;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [OW-1:0] low_next;

        if (k == 0) begin : g_first
            assign rem_in   = NW'(hi_ext);
            assign low_in   = dividend[OW-1:0];
            assign dvs_in   = divisor;
            assign ovf_in_k = ovf_in;
        end
        else begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign low_in   = low_reg[k-1];
            assign dvs_in   = dvs_reg[k-1];
            assign ovf_in_k = ovf_reg[k-1];
        end

        always_comb
        begin
            trial    = {rem_in, low_in[OW-1]};
            ge       = (trial >= {1'b0, dvs_in});
            rem_next = ge ? NW'(trial - {1'b0, dvs_in}) : NW'(trial);
            low_next = {low_in[OW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_next;
                dvs_reg[k] <= dvs_in;
                ovf_reg[k] <= ovf_in_k;
            end
        end
    end

    assign quotient = ovf_reg[STEPS-1] ? {OW{1'b1}} : low_reg[STEPS-1];

endmodule

`default_nettype wire

// ----- src/pixel_mean_stddev_from_sums.sv -----
// ----------------------------------------------------------------------------
// pixel_mean_stddev_from_sums
// Mean and population standard deviation of one pixel from its sample sums.
// ----------------------------------------------------------------------------
// Usage: each input beat carries sample_sum, square_sum and valid_count for
// one pixel on a valid/ready channel. Each output beat carries mean_depth and
// std_deviation, unsigned fixed point with FRAC_BITS fraction bits and
// truncated, plus has_samples. A zero count gives zeros and has_samples low.
// The datapath is one long pipeline: an input register, a multiply stage, a
// subtract stage, 32 + FRAC_BITS square-root stages (one root bit each) and
// a 24-stage divider (one quotient bit each). The mean divider runs beside
// the root stages and its result is delayed to meet the deviation.
// One beat is taken every cycle while no held result freezes the pipeline.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated. Empty
// stages never block. Reset clears all valid bits; the data registers have no
// reset and there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_mean_stddev_from_sums #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pmsd_pkg::SUM_W-1:0]    sample_sum,
    input  wire logic [pmsd_pkg::SQS_W-1:0]    square_sum,
    input  wire logic [pmsd_pkg::CNT_W-1:0]    valid_count,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [pmsd_pkg::OUT_W-1:0]    mean_depth,
    output logic      [pmsd_pkg::OUT_W-1:0]    std_deviation,
    output logic                               has_samples
);

    localparam int SW    = pmsd_pkg::SUM_W;
    localparam int QW    = pmsd_pkg::SQS_W;
    localparam int NW    = pmsd_pkg::CNT_W;
    localparam int OW    = pmsd_pkg::OUT_W;
    localparam int PW    = pmsd_pkg::PROD_W;
    localparam int PAIRS = SW + FRAC_BITS;
    localparam int RTW   = SW + FRAC_BITS;
    localparam int RMW   = RTW + 2;
    localparam int LAST  = 2 + PAIRS + OW;
    localparam int MD    = LAST - OW;

    logic en;

    logic [LAST:0]   vld_reg;
    logic [LAST:0]   hs_reg;

    logic [SW-1:0]   s0_reg;
    logic [QW-1:0]   q0_reg;
    logic [NW-1:0]   n0_reg;
    logic [PW-1:0]   prod1_reg;
    logic [PW-1:0]   sq1_reg;
    logic [NW-1:0]   n1_reg;

    logic [PW-1:0]   rt_v_reg    [PAIRS+1];
    logic [RTW-1:0]  rt_root_reg [PAIRS+1];
    logic [RMW-1:0]  rt_rem_reg  [PAIRS+1];
    logic [NW-1:0]   rt_n_reg    [PAIRS+1];

    logic [OW-1:0]   mean_q;
    logic [OW-1:0]   sd_q;
    logic [OW-1:0]   md_reg [MD];
    logic [RTW-1:0]  mean_dividend;

    // The pipeline advances as a whole unless a finished result is held.
    assign en       = !vld_reg[LAST] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hs_reg    <= {hs_reg[LAST-1:0], (valid_count != '0)};
            s0_reg    <= sample_sum;
            q0_reg    <= square_sum;
            n0_reg    <= valid_count;
            prod1_reg <= PW'(q0_reg) * PW'(n0_reg);
            sq1_reg   <= PW'(s0_reg) * PW'(s0_reg);
            n1_reg    <= n0_reg;
            // Inconsistent sums can drive the variance negative; clamp it.
            rt_v_reg[0]    <= (prod1_reg >= sq1_reg) ? (prod1_reg - sq1_reg) : '0;
            rt_root_reg[0] <= '0;
            rt_rem_reg[0]  <= '0;
            rt_n_reg[0]    <= n1_reg;
        end
    end

    // Restoring square root, one bit pair per stage. After the 32 pairs of
    // the variance, zero pairs bring in the fraction bits of the root.
    for (genvar i = 0; i < PAIRS; i++) begin : g_root
        logic [RMW-1:0] rem2;
        logic [RMW-1:0] trial;
        logic           ge;

        always_comb
        begin
            rem2  = {rt_rem_reg[i][RMW-3:0], rt_v_reg[i][PW-1:PW-2]};
            trial = {rt_root_reg[i], 2'b01};
            ge    = (rem2 >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_v_reg[i+1]    <= {rt_v_reg[i][PW-3:0], 2'b00};
                rt_root_reg[i+1] <= {rt_root_reg[i][RTW-2:0], ge};
                rt_rem_reg[i+1]  <= ge ? (rem2 - trial) : rem2;
                rt_n_reg[i+1]    <= rt_n_reg[i];
            end
        end
    end

    assign mean_dividend = RTW'(s0_reg) << FRAC_BITS;

    pmsd_divider #(
        .DIVIDEND_W (RTW)
    ) u_mean_div (
        .clk      (clk),
        .en       (en),
        .dividend (mean_dividend),
        .divisor  (n0_reg),
        .quotient (mean_q)
    );

    pmsd_divider #(
        .DIVIDEND_W (RTW)
    ) u_sd_div (
        .clk      (clk),
        .en       (en),
        .dividend (rt_root_reg[PAIRS]),
        .divisor  (rt_n_reg[PAIRS]),
        .quotient (sd_q)
    );

    // The mean is ready long before the deviation; hold it in step.
    for (genvar j = 0; j < MD; j++) begin : g_mean_dly
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                md_reg[j] <= (j == 0) ? mean_q : md_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    assign out_valid     = vld_reg[LAST];
    assign has_samples   = hs_reg[LAST];
    assign mean_depth    = hs_reg[LAST] ? md_reg[MD-1] : '0;
    assign std_deviation = hs_reg[LAST] ? sd_q : '0;

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_samples |-> mean_depth == '0 && std_deviation == '0)
        else $error("empty pixel gave nonzero result");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vld_reg))
        else $error("pipeline moved while the result was held");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with no result waiting");

endmodule

`default_nettype wire

// ----- bench/pixel_mean_stddev_from_sums_tb.sv -----
// ----------------------------------------------------------------------------
// pixel_mean_stddev_from_sums_tb
// Checks per-pixel mean and standard deviation against a local predictor.
// ----------------------------------------------------------------------------
// Directed corner cases run first, then random pixels: consistent sums built
// from real sample sets, plus raw values over the full field ranges. The
// sender and receiver idle in short random bursts, and one phase holds the
// receiver off long enough that the pipeline fills and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_mean_stddev_from_sums_tb;

    localparam int SUM_W     = pmsd_pkg::SUM_W;
    localparam int SQS_W     = pmsd_pkg::SQS_W;
    localparam int CNT_W     = pmsd_pkg::CNT_W;
    localparam int OUT_W     = pmsd_pkg::OUT_W;
    localparam int FRAC_BITS = 8;
    localparam int LATENCY   = 59 + FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_SAT = '1;

    typedef struct packed {
        logic [OUT_W-1:0] mean;
        logic [OUT_W-1:0] sdev;
        logic             has;
    } pixel_stats_t;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [SUM_W-1:0] sample_sum;
    logic [SQS_W-1:0] square_sum;
    logic [CNT_W-1:0] valid_count;
    logic             out_valid;
    logic             out_ready;
    logic [OUT_W-1:0] mean_depth;
    logic [OUT_W-1:0] std_deviation;
    logic             has_samples;

    pixel_stats_t stats_q[$];
    int           errors;
    bit           sender_idles;
    bit           receiver_idles;
    int           hold_off_cycles;

    pixel_mean_stddev_from_sums #(.FRAC_BITS(FRAC_BITS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_sum    (sample_sum),
        .square_sum    (square_sum),
        .valid_count   (valid_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mean_depth    (mean_depth),
        .std_deviation (std_deviation),
        .has_samples   (has_samples)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Restoring root of var * 4^FRAC_BITS, one bit pair at a time.
    function automatic logic [63:0] scaled_root(input logic [63:0] v);
        logic [63:0] root;
        logic [67:0] rem;
        logic [67:0] trial;
        logic [1:0]  pair;
        root = '0;
        rem  = '0;
        for (int i = 0; i < 32 + FRAC_BITS; i++)
        begin
            pair  = (i < 32) ? v[63 - 2*i -: 2] : 2'b00;
            rem   = {rem[65:0], pair};
            trial = {root, 2'b01};
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = {root[62:0], 1'b1};
            end
            else
                root = {root[62:0], 1'b0};
        end
        return root;
    endfunction

    function automatic pixel_stats_t predict_stats(input logic [SUM_W-1:0] s,
                                                   input logic [SQS_W-1:0] q,
                                                   input logic [CNT_W-1:0] n);
        pixel_stats_t r;
        logic [63:0]  mean;
        logic [63:0]  sdev;
        logic [63:0]  prod;
        logic [63:0]  sq;
        logic [63:0]  var_val;
        r = '0;
        if (n == 0)
            return r;
        mean    = ({32'd0, s} << FRAC_BITS) / n;
        prod    = {16'd0, q} * {48'd0, n};
        sq      = {32'd0, s} * {32'd0, s};
        var_val = (prod >= sq) ? prod - sq : 64'd0;
        sdev    = scaled_root(var_val) / n;
        r.mean  = (mean > OUT_SAT) ? OUT_SAT : mean[OUT_W-1:0];
        r.sdev  = (sdev > OUT_SAT) ? OUT_SAT : sdev[OUT_W-1:0];
        r.has   = 1'b1;
        return r;
    endfunction

    // Valid stays high after a beat so the next one can follow at once; it
    // drops only when the sender idles or waits for the pipeline to drain.
    task automatic send_pixel(input logic [SUM_W-1:0] s, input logic [SQS_W-1:0] q,
                              input logic [CNT_W-1:0] n);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_sum  <= s;
        square_sum  <= q;
        valid_count <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        stats_q.push_back(predict_stats(s, q, n));
    endtask

    // Builds consistent sums from n random samples of a random spread.
    task automatic send_sample_set(input int n);
        logic [SUM_W-1:0] s;
        logic [SQS_W-1:0] q;
        int base;
        int spread;
        int x;
        s      = '0;
        q      = '0;
        base   = $urandom_range(0, 65535);
        spread = 1 << $urandom_range(0, 16);
        for (int i = 0; i < n; i++)
        begin
            x = base + $urandom_range(0, spread - 1);
            if (x > 65535)
                x = 65535;
            s = s + x;
            q = q + 48'(x) * 48'(x);
        end
        send_pixel(s, q, n[CNT_W-1:0]);
    endtask

    task automatic send_raw_pixel();
        logic [SQS_W-1:0] q;
        logic [CNT_W-1:0] n;
        q = SQS_W'({$urandom, $urandom});
        n = $urandom_range(0, 1) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 4));
        send_pixel($urandom, q, n);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (stats_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corners();
        send_pixel('0, '0, '0);
        send_pixel('1, '1, '0);
        send_pixel(32'd1000, 48'd1000000, 16'd1);
        send_pixel(32'd65535, 48'd4294836225, 16'd1);
        send_pixel(32'd4294836225, 48'd281462092005375, 16'd65535);
        send_pixel(32'd10, 48'd50, 16'd2);               // variance 0
        send_pixel(32'd10, 48'd40, 16'd2);               // negative variance
        send_pixel(32'd3, 48'd5, 16'd2);                 // samples 1 and 2
        send_pixel('1, '1, 16'd1);                       // mean saturates
        send_pixel('1, '0, 16'd65535);
        send_pixel('0, '1, 16'd65535);
        send_pixel(32'd1, 48'd1, 16'd65535);
        send_pixel(32'd65535, '1, 16'd1);
        send_pixel(32'h5555_5555, 48'haaaa_aaaa_aaaa, 16'haaaa);
        send_pixel(32'haaaa_aaaa, 48'h5555_5555_5555, 16'h5555);
        wait_drained();
    endtask

    task automatic test_random_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                send_sample_set($urandom_range(1, 12));
            else
                send_raw_pixel();
        end
    endtask

    task automatic test_full_pipeline();
        hold_off_cycles = 150;
        for (int i = 0; i < 120; i++)
            send_sample_set($urandom_range(1, 8));
        wait_drained();
    endtask

    // Result side: random ready bursts and a counted long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_ready       <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (receiver_idles && $urandom_range(0, 4) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        pixel_stats_t exp_stats;
        if (rst_n && out_valid && out_ready)
        begin
            if (stats_q.size() == 0)
            begin
                $display("%0t: unexpected beat mean=%h sdev=%h has=%b", $time,
                         mean_depth, std_deviation, has_samples);
                errors++;
            end
            else
            begin
                exp_stats = stats_q.pop_front();
                if (mean_depth !== exp_stats.mean)
                begin
                    $display("%0t: mean_depth expected %h actual %h", $time,
                             exp_stats.mean, mean_depth);
                    errors++;
                end
                if (std_deviation !== exp_stats.sdev)
                begin
                    $display("%0t: std_deviation expected %h actual %h", $time,
                             exp_stats.sdev, std_deviation);
                    errors++;
                end
                if (has_samples !== exp_stats.has)
                begin
                    $display("%0t: has_samples expected %b actual %b", $time,
                             exp_stats.has, has_samples);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors          = 0;
        hold_off_cycles = 0;
        sender_idles    = 1'b1;
        receiver_idles  = 1'b1;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        sample_sum      = '0;
        square_sum      = '0;
        valid_count     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_full_pipeline();
        test_random_pixels(1400);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_pixels(350);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0 && stats_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
